FILE: design/fssmm_pkg.sv
// ----------------------------------------------------------------------------
// fssmm_pkg
// shared types for the fraction set sum / max / min block
// ----------------------------------------------------------------------------
package fssmm_pkg;

  // request from the sequencer to the shift-subtract divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: design/fssmm_div.sv
// ----------------------------------------------------------------------------
// fssmm_div
// restoring shift-subtract divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fssmm_div #(
  parameter int WIDTH = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fssmm_pkg::div_ctl_t ctl_i,
  input  logic [WIDTH-1:0]    dividend_i,
  input  logic [WIDTH-1:0]    divisor_i,
  output fssmm_pkg::div_sts_t sts_o,
  output logic [WIDTH-1:0]    quotient_o
);
  import fssmm_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [WIDTH-1:0] rem_q, dv_q, ds_q;
  logic [WIDTH:0]   trial;
  logic             fits;

  assign trial = {rem_q, dv_q[WIDTH-1]};
  assign fits  = trial >= {1'b0, ds_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        cnt_q  <= CW'(WIDTH);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= '0;
      dv_q  <= dividend_i;
      ds_q  <= divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits in WIDTH bits
      rem_q <= fits ? WIDTH'(trial - {1'b0, ds_q}) : trial[WIDTH-1:0];
      dv_q  <= {dv_q[WIDTH-2:0], fits};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = dv_q;

endmodule

FILE: design/fraction_set_sum_max_min_top.sv
// ----------------------------------------------------------------------------
// fraction_set_sum_max_min_top
// running rational sum with binary gcd reduction, plus max and min fraction
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid_i in_stall_o num/den/last    | word in
//  out     | out_valid_o out_stall_i sum/max/min.. | word out
//
//  one word at a time; in_stall_o is high from acceptance until the sequencer
//  returns to idle. a word passes through the cross-product multiplies, the
//  binary gcd (data dependent), two divider passes and the max and min
//  multiply and compare. a zero-denominator word goes straight to the finish
//  state. the result sits in an output register; a stalled result holds the
//  sequencer at the end of the next set. reset clears the sum to 0/1 and all
//  flags.
module fraction_set_sum_max_min_top #(
  parameter int IN_WIDTH  = 16,
  parameter int SUM_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [IN_WIDTH-1:0]  num_i,
  input  logic signed [IN_WIDTH-1:0]  den_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [SUM_WIDTH-1:0] sum_num_o,
  output logic [SUM_WIDTH-2:0]        sum_den_o,
  output logic signed [IN_WIDTH-1:0]  max_num_o,
  output logic [IN_WIDTH-1:0]         max_den_o,
  output logic signed [IN_WIDTH-1:0]  min_num_o,
  output logic [IN_WIDTH-1:0]         min_den_o,
  output logic                        overflow_o,
  output logic                        bad_input_o,
  output logic                        empty_set_o
);
  import fssmm_pkg::*;

  localparam int W  = IN_WIDTH;
  localparam int S  = SUM_WIDTH;
  localparam int P  = S + W;
  localparam int KW = $clog2(P + 1);
  localparam logic [P-1:0] TOP = P'(1) << (S - 1);
  localparam logic signed [W:0] LIM = (W+1)'((1 << (W - 1)) - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_T1, ST_T2, ST_ND, ST_GCD, ST_DIV_NUM, ST_DIV_DEN, ST_UPDATE,
    ST_HI_A, ST_HI_B, ST_LO_A, ST_LO_B, ST_PICK, ST_FINISH
  } state_e;

  state_e state_q;

  logic signed [S-1:0] acc_num_q;
  logic [S-2:0]        acc_den_q;
  logic signed [W:0]   hi_num_q, lo_num_q, nn_q;
  logic [W-1:0]        hi_den_q, lo_den_q, dd_q;
  logic                seen_q, ovf_q, bad_q, last_q;
  logic [P-1:0]        t1_q, t2_q, mag_q, nd_q, ga_q, gb_q, qn_q;
  logic                neg_q;
  logic [KW-1:0]       gk_q;
  logic signed [P+1:0] pa_q, pb_q, pc_q, pd_q;
  logic                out_valid_q;
  div_ctl_t            div_ctl_q;
  div_sts_t            div_sts;
  logic [P-1:0]        div_quo, div_dvd, gcd_val;

  // input normalization
  logic signed [W:0]   n_ext, d_ext, nn_in, dd_in;
  assign n_ext = (W+1)'(num_i);
  assign d_ext = (W+1)'(den_i);
  assign nn_in = den_i[W-1] ? -n_ext : n_ext;
  assign dd_in = den_i[W-1] ? -d_ext : d_ext;

  // magnitudes of the operands
  logic         sa, sx;
  logic [S-1:0] ma;
  logic [W-1:0] mx;
  assign sa = acc_num_q[S-1];
  assign ma = sa ? S'(-acc_num_q) : S'(acc_num_q);
  assign sx = nn_q[W];
  assign mx = sx ? W'(-nn_q) : W'(nn_q);

  // shared signed multiplier
  logic signed [S:0]     op_a;
  logic signed [W:0]     op_b;
  logic signed [P+1:0]   mul_res;
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      ST_T1:   begin op_a = {1'b0, ma};           op_b = {1'b0, dd_q}; end
      ST_T2:   begin op_a = {2'b00, acc_den_q};   op_b = {1'b0, mx};   end
      ST_ND:   begin op_a = {2'b00, acc_den_q};   op_b = {1'b0, dd_q}; end
      ST_HI_A: begin op_a = (S+1)'(nn_q);         op_b = {1'b0, hi_den_q}; end
      ST_HI_B: begin op_a = (S+1)'(hi_num_q);     op_b = {1'b0, dd_q}; end
      ST_LO_A: begin op_a = (S+1)'(nn_q);         op_b = {1'b0, lo_den_q}; end
      ST_LO_B: begin op_a = (S+1)'(lo_num_q);     op_b = {1'b0, dd_q}; end
      default: begin op_a = '0;                   op_b = '0;           end
    endcase
  end
  assign mul_res = op_a * op_b;

  // signed add of the two cross products
  logic [P-1:0] mag_c;
  logic         neg_c;
  always_comb begin
    if (sa == sx) begin
      mag_c = t1_q + t2_q;
      neg_c = sa;
    end else if (t1_q >= t2_q) begin
      mag_c = t1_q - t2_q;
      neg_c = sa;
    end else begin
      mag_c = t2_q - t1_q;
      neg_c = sx;
    end
  end

  assign gcd_val = gb_q << gk_q;
  assign div_dvd = (state_q == ST_DIV_DEN) ? nd_q : mag_q;

  fssmm_div #(.WIDTH(P)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl_q),
    .dividend_i (div_dvd),
    .divisor_i  (gcd_val),
    .sts_o      (div_sts),
    .quotient_o (div_quo)
  );

  logic ovf_c;
  assign ovf_c = (neg_q ? (qn_q > TOP) : (qn_q > TOP - 1'b1)) || (div_quo > TOP - 1'b1);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_num_q   <= '0;
      acc_den_q   <= (S-1)'(1);
      hi_num_q    <= '0;
      hi_den_q    <= W'(1);
      lo_num_q    <= '0;
      lo_den_q    <= W'(1);
      seen_q      <= 1'b0;
      ovf_q       <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      div_ctl_q   <= '0;
    end else begin
      div_ctl_q <= '0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (den_i == '0) begin
              bad_q   <= 1'b1;
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_T1;
            end
          end
        end
        ST_T1:   state_q <= ST_T2;
        ST_T2:   state_q <= ST_ND;
        ST_ND:   state_q <= ST_GCD;
        ST_GCD: begin
          if (ga_q == '0) begin
            div_ctl_q.start <= 1'b1;
            state_q         <= ST_DIV_NUM;
          end
        end
        ST_DIV_NUM: begin
          if (div_sts.done) begin
            div_ctl_q.start <= 1'b1;
            state_q         <= ST_DIV_DEN;
          end
        end
        ST_DIV_DEN: begin
          if (div_sts.done) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          // div_quo still holds the reduced denominator here
          if (ovf_c) begin
            ovf_q <= 1'b1;
          end else begin
            acc_num_q <= neg_q ? -S'(qn_q) : S'(qn_q);
            acc_den_q <= div_quo[S-2:0];
          end
          if (!seen_q) begin
            hi_num_q <= nn_q;
            hi_den_q <= dd_q;
            lo_num_q <= nn_q;
            lo_den_q <= dd_q;
            seen_q   <= 1'b1;
            state_q  <= ST_FINISH;
          end else begin
            state_q <= ST_HI_A;
          end
        end
        ST_HI_A: state_q <= ST_HI_B;
        ST_HI_B: state_q <= ST_LO_A;
        ST_LO_A: state_q <= ST_LO_B;
        ST_LO_B: state_q <= ST_PICK;
        ST_PICK: begin
          if (pa_q > pb_q) begin
            hi_num_q <= nn_q;
            hi_den_q <= dd_q;
          end
          if (pc_q < pd_q) begin
            lo_num_q <= nn_q;
            lo_den_q <= dd_q;
          end
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            acc_num_q   <= '0;
            acc_den_q   <= (S-1)'(1);
            hi_num_q    <= '0;
            hi_den_q    <= W'(1);
            lo_num_q    <= '0;
            lo_den_q    <= W'(1);
            seen_q      <= 1'b0;
            ovf_q       <= 1'b0;
            bad_q       <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          nn_q   <= nn_in;
          dd_q   <= dd_in[W-1:0];
          last_q <= last_i;
        end
      end
      ST_T1: t1_q <= mul_res[P-1:0];
      ST_T2: t2_q <= mul_res[P-1:0];
      ST_ND: begin
        nd_q  <= mul_res[P-1:0];
        mag_q <= mag_c;
        neg_q <= neg_c && (mag_c != '0);
        ga_q  <= mag_c;
        gb_q  <= mul_res[P-1:0];
        gk_q  <= '0;
      end
      ST_GCD: begin
        // binary gcd, one shift or subtract per cycle
        if (ga_q != '0) begin
          priority if (!ga_q[0] && !gb_q[0]) begin
            ga_q <= ga_q >> 1;
            gb_q <= gb_q >> 1;
            gk_q <= gk_q + 1'b1;
          end else if (!ga_q[0]) begin
            ga_q <= ga_q >> 1;
          end else if (!gb_q[0]) begin
            gb_q <= gb_q >> 1;
          end else if (ga_q >= gb_q) begin
            ga_q <= (ga_q - gb_q) >> 1;
          end else begin
            gb_q <= (gb_q - ga_q) >> 1;
          end
        end
      end
      ST_DIV_NUM: begin
        if (div_sts.done) begin
          qn_q <= div_quo;
        end
      end
      ST_HI_A: pa_q <= mul_res;
      ST_HI_B: pb_q <= mul_res;
      ST_LO_A: pc_q <= mul_res;
      ST_LO_B: pd_q <= mul_res;
      default: begin
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && last_q && out_free) begin
      sum_num_o   <= acc_num_q;
      sum_den_o   <= acc_den_q;
      max_num_o   <= (hi_num_q > LIM) ? W'(LIM) : W'(hi_num_q);
      max_den_o   <= hi_den_q;
      min_num_o   <= (lo_num_q > LIM) ? W'(LIM) : W'(lo_num_q);
      min_den_o   <= lo_den_q;
      overflow_o  <= ovf_q;
      bad_input_o <= bad_q;
      empty_set_o <= !seen_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_den_q != '0) else $error("sum denominator is zero");

  a_gcd_b_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GCD |-> gb_q != '0) else $error("gcd operand lost");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(sum_num_o))
    else $error("stalled result word changed");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl_q.start |-> !div_sts.busy) else $error("divider restarted while busy");
`endif

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for fraction_set_sum_max_min_top. A driver sends
// fraction words from a queue. Each accepted word goes through an exact
// software model of the running sum, the max and the min, and the model
// queues the result that it expects. A monitor compares every result word
// with the oldest expected one. The run has a directed part, then several
// idle/stall phases of random sets, a long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 4000000;
  localparam int TailCycles = 600;

  typedef struct {
    logic signed [15:0] num;
    logic signed [15:0] den;
    logic               last;
  } frac_word_t;

  typedef struct {
    logic signed [31:0] sum_num;
    logic [30:0]        sum_den;
    logic signed [15:0] max_num;
    logic [15:0]        max_den;
    logic signed [15:0] min_num;
    logic [15:0]        min_den;
    logic               overflow;
    logic               bad_input;
    logic               empty_set;
  } set_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic signed [15:0] num_i = '0;
  logic signed [15:0] den_i = 16'sd1;
  logic last_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o;
  logic signed [31:0] sum_num_o;
  logic [30:0] sum_den_o;
  logic signed [15:0] max_num_o, min_num_o;
  logic [15:0] max_den_o, min_den_o;
  logic overflow_o, bad_input_o, empty_set_o;

  fraction_set_sum_max_min_top uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  frac_word_t  pending_words[$];
  set_result_t expected_sets[$];
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int cycles = 0;
  int words_sent = 0, sets_done = 0, ovf_sets = 0, bad_sets = 0, empty_sets = 0;

  // running state of the set
  logic signed [31:0] run_num;
  logic [30:0]        run_den;
  longint hi_num, hi_den, lo_num, lo_den;
  bit seen_frac, ovf_seen, bad_seen;

  task automatic clear_set();
    run_num = '0; run_den = 31'd1;
    hi_num = 0; hi_den = 1; lo_num = 0; lo_den = 1;
    seen_frac = 0; ovf_seen = 0; bad_seen = 0;
  endtask

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic logic signed [15:0] sat_num(longint v);
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  task automatic add_fraction(longint n, longint d);
    longint a, g;
    longint unsigned ma, mx, t1, t2, mag, nd, gg;
    bit sa, sx, neg;
    a = run_num;
    sa = a < 0;
    ma = sa ? -a : a;
    sx = n < 0;
    mx = sx ? -n : n;
    t1 = ma * d;
    t2 = longint'(run_den) * mx;
    nd = longint'(run_den) * d;
    if (sa == sx) begin
      mag = t1 + t2; neg = sa;
    end else if (t1 >= t2) begin
      mag = t1 - t2; neg = sa;
    end else begin
      mag = t2 - t1; neg = sx;
    end
    gg = gcd64(mag, nd);
    if (gg == 0) gg = 1;
    mag = mag / gg;
    nd = nd / gg;
    if (mag == 0) neg = 0;
    if ((neg ? (mag > 64'h8000_0000) : (mag > 64'h7fff_ffff)) || nd > 64'h7fff_ffff) begin
      ovf_seen = 1;
      return;
    end
    g = neg ? -longint'(mag) : longint'(mag);
    run_num = g[31:0];
    run_den = nd[30:0];
  endtask

  task automatic predict_word(frac_word_t w);
    longint n, d;
    set_result_t r;
    n = w.num;
    d = w.den;
    if (d == 0) begin
      bad_seen = 1;
    end else begin
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      add_fraction(n, d);
      if (!seen_frac) begin
        hi_num = n; hi_den = d; lo_num = n; lo_den = d;
        seen_frac = 1;
      end else begin
        if (n * hi_den > hi_num * d) begin
          hi_num = n; hi_den = d;
        end
        if (n * lo_den < lo_num * d) begin
          lo_num = n; lo_den = d;
        end
      end
    end
    if (w.last) begin
      r.sum_num = run_num;
      r.sum_den = run_den;
      r.max_num = sat_num(hi_num);
      r.max_den = hi_den[15:0];
      r.min_num = sat_num(lo_num);
      r.min_den = lo_den[15:0];
      r.overflow = ovf_seen;
      r.bad_input = bad_seen;
      r.empty_set = !seen_frac;
      expected_sets.push_back(r);
      clear_set();
    end
  endtask

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("MISMATCH set %0d %s: got %0d, want %0d", sets_done, what, got, want);
  endtask

  // driver
  always @(posedge clk_i) begin
    frac_word_t w;
    logic nxt_valid;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        w = pending_words.pop_front();
        predict_word(w);
        words_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_words.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        w = pending_words[0];
        num_i <= w.num;
        den_i <= w.den;
        last_i <= w.last;
        nxt_valid = 1'b1;
      end
      in_valid_i <= nxt_valid;
    end
  end

  // receiver stall and long hold-off counter
  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    out_stall_i <= (hold_cycles > 1) || ($urandom_range(99) < recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    set_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_sets.size() == 0) begin
        report("result word with nothing expected", 1, 0);
      end else begin
        e = expected_sets.pop_front();
        if (sum_num_o !== e.sum_num) report("sum_num", sum_num_o, e.sum_num);
        if (sum_den_o !== e.sum_den) report("sum_den", sum_den_o, e.sum_den);
        if (max_num_o !== e.max_num) report("max_num", max_num_o, e.max_num);
        if (max_den_o !== e.max_den) report("max_den", max_den_o, e.max_den);
        if (min_num_o !== e.min_num) report("min_num", min_num_o, e.min_num);
        if (min_den_o !== e.min_den) report("min_den", min_den_o, e.min_den);
        if (overflow_o !== e.overflow) report("overflow", overflow_o, e.overflow);
        if (bad_input_o !== e.bad_input) report("bad_input", bad_input_o, e.bad_input);
        if (empty_set_o !== e.empty_set) report("empty_set", empty_set_o, e.empty_set);
        if (e.overflow) ovf_sets++;
        if (e.bad_input) bad_sets++;
        if (e.empty_set) empty_sets++;
      end
      sets_done++;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_word(int n, int d, bit lst);
    frac_word_t w;
    w.num = n[15:0];
    w.den = d[15:0];
    w.last = lst;
    pending_words.push_back(w);
  endtask

  function automatic int pick_num();
    case ($urandom_range(9))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return $urandom_range(1, 20) - 10;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  function automatic int pick_den();
    int s;
    s = $urandom_range(1) ? -1 : 1;
    case ($urandom_range(19))
      0: return 0;
      1: return -32768;
      2: return 32767;
      3, 4: return $signed(16'($urandom));
      default: return s * $urandom_range(1, 12);
    endcase
  endfunction

  task automatic push_random_set();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      // now and then a broken set with stray last flags
      if ($urandom_range(9) == 0)
        push_word(pick_num(), pick_den(), $urandom_range(1));
      else
        push_word(pick_num(), pick_den(), i == len - 1);
    end
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || expected_sets.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(int idle, int stall, int nsets);
    sender_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < nsets; i++) push_random_set();
    drain();
  endtask

  initial begin
    clear_set();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, negative dens, zero den, ties, overflow, empty set
    push_word(0, 1, 1);
    push_word(-32768, -32768, 0);
    push_word(32767, -32768, 0);
    push_word(-32768, 1, 1);
    push_word(-32768, -1, 1);
    push_word(3, -4, 0);
    push_word(-3, 4, 0);
    push_word(6, -8, 1);
    push_word(5, 0, 0);
    push_word(1, 2, 0);
    push_word(-1, 2, 1);
    push_word(7, 0, 1);
    push_word(1, 32767, 0);
    push_word(1, 32765, 0);
    push_word(1, 32763, 0);
    push_word(1, 32761, 0);
    push_word(32767, 1, 1);
    push_word(-32768, 32767, 0);
    push_word(32767, 32767, 1);
    push_word(1, 3, 0);
    push_word(2, 6, 1);
    drain();

    run_phase(0, 0, 70);
    run_phase(65, 0, 70);
    run_phase(0, 65, 70);
    run_phase(27, 27, 70);

    // long output hold-off while words keep coming
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 6000;
    for (int i = 0; i < 20; i++) push_random_set();
    drain();

    run_phase(0, 0, 60);
    run_phase(27, 27, 40);

    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d words in %0d sets: %0d overflow, %0d zero-den, %0d empty",
             words_sent, sets_done, ovf_sets, bad_sets, empty_sets);
    if (errors == 0 && expected_sets.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
